>>> hdl/rmf_pkg.sv
// ----------------------------------------------------------------------------
// rmf_pkg
// Shared types and constants for the running median filter.
// ----------------------------------------------------------------------------
package rmf_pkg;

    localparam int SAMPLE_W       = 16;   // sample and median width
    localparam int WS_W           = 3;    // window_size register width
    localparam int MIN_WINDOW     = 3;    // shortest effective window
    localparam int MAX_WINDOW_DEF = 7;    // default store depth

    localparam logic [WS_W-1:0] WS_RESET = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,     // waiting for a sample beat
        S_SCAN,     // testing one candidate per cycle
        S_WAIT      // median found, output register still occupied
    } t_rmf_state;

    // controller -> datapath
    typedef struct packed {
        logic wr_sample;    // store sample, advance pointer and fill, restart scan
        logic cand_inc;     // move to next candidate
        logic out_load;     // capture current candidate into output register
    } t_rmf_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hit;          // current candidate has the median rank
        logic cand_last;    // current candidate is the last held entry
    } t_rmf_stat;

endpackage

>>> hdl/rmf_sample_if.sv
// ----------------------------------------------------------------------------
// rmf_sample_if
// Valid/ready channel carrying one input sample per beat.
// ----------------------------------------------------------------------------
interface rmf_sample_if import rmf_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

>>> hdl/rmf_median_if.sv
// ----------------------------------------------------------------------------
// rmf_median_if
// Valid/ready channel carrying one median result per beat.
// ----------------------------------------------------------------------------
interface rmf_median_if import rmf_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);

endinterface

>>> hdl/running_median_filter.sv
// ----------------------------------------------------------------------------
// running_median_filter
// Sliding-window median over the last 3, 5 or 7 signed 16-bit samples.
// ----------------------------------------------------------------------------
//  Channel      Dir  Handshake      Payload
//  i_sample_if  in   valid/ready    sample  (signed 16)
//  o_median_if  out  valid/ready    median  (signed 16)
//  i_cfg_wr_*   in   write enable   window_size (3 bits, reset 5)
//
//  Each beat first writes the sample into the store, then ranks one
//  candidate per cycle against all held entries in parallel, at most n
//  candidates, n = samples held (at most the window length).
//  The scan stops early at the first candidate that holds the median rank.
//  The result sits in an output register; the next sample is taken while it
//  waits. A stalled result stalls only a finished scan.
//  Reset (sync, active low) sets window_size to 5 and empties the window;
//  a window_size write empties it as well. No clearing pass is needed.
// ----------------------------------------------------------------------------
module running_median_filter import rmf_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [WS_W-1:0] i_cfg_wr_data,
    rmf_sample_if.sink      i_sample_if,
    rmf_median_if.source    o_median_if
);

    t_rmf_cmd  cmd;
    t_rmf_stat stat;

    // local copies of the handshakes, also watched by the checker
    logic in_valid, in_ready, out_valid, out_ready;

    assign in_valid          = i_sample_if.valid;
    assign i_sample_if.ready = in_ready;
    assign out_ready         = o_median_if.ready;
    assign o_median_if.valid = out_valid;

    // sequencer: owns the handshakes and the scan order
    rmf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // store, pointers, rank compare and result register
    rmf_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_sample      (i_sample_if.sample),
        .o_median      (o_median_if.median),
        .i_cmd         (cmd),
        .o_stat        (stat)
    );

endmodule

>>> hdl/rmf_ctrl.sv
// ----------------------------------------------------------------------------
// rmf_ctrl
// Sequencer: accepts a sample, steps the rank scan, hands off the result.
// ----------------------------------------------------------------------------
module rmf_ctrl import rmf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    input  t_rmf_stat i_stat,
    output t_rmf_cmd  o_cmd
);

    t_rmf_state r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // a hit always exists; the last candidate ends the scan regardless
                if (i_stat.hit || i_stat.cand_last) begin
                    n_state = out_free ? S_IDLE : S_WAIT;
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.wr_sample = i_in_valid;
            end
            S_SCAN: begin
                if (i_stat.hit || i_stat.cand_last) begin
                    o_cmd.out_load = out_free;
                end else begin
                    o_cmd.cand_inc = 1'b1;
                end
            end
            S_WAIT: begin
                o_cmd.out_load = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> hdl/rmf_datapath.sv
// ----------------------------------------------------------------------------
// rmf_datapath
// Window store, pointers, rank test of one candidate and output register.
// ----------------------------------------------------------------------------
module rmf_datapath import rmf_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [WS_W-1:0]            i_cfg_wr_data,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic signed [SAMPLE_W-1:0] o_median,
    input  t_rmf_cmd                   i_cmd,
    output t_rmf_stat                  o_stat
);

    localparam int IDX_W = $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int EXT_W = CNT_W + WS_W;

    logic signed [SAMPLE_W-1:0] r_store [MAX_WINDOW];
    logic [WS_W-1:0]            r_ws;
    logic [IDX_W-1:0]           r_wp, n_wp;
    logic [CNT_W-1:0]           r_fill, n_fill;
    logic [IDX_W-1:0]           r_cand;
    logic signed [SAMPLE_W-1:0] r_median;

    logic [EXT_W-1:0]           len_lo, len_hi;
    logic [CNT_W-1:0]           len;
    logic [CNT_W-1:0]           wp_inc;
    logic signed [SAMPLE_W-1:0] cand_val;
    logic [CNT_W-1:0]           less_cnt, le_cnt, rank;

    // effective window: clamp to [3, MAX_WINDOW], then force odd
    always_comb begin
        len_lo = (EXT_W'(r_ws) < EXT_W'(MIN_WINDOW)) ? EXT_W'(MIN_WINDOW) : EXT_W'(r_ws);
        len_hi = (len_lo > EXT_W'(MAX_WINDOW)) ? EXT_W'(MAX_WINDOW) : len_lo;
        if (!len_hi[0]) begin
            len_hi = len_hi - EXT_W'(1);
        end
        len = len_hi[CNT_W-1:0];
    end

    always_comb begin
        wp_inc = CNT_W'(r_wp) + CNT_W'(1);
        n_wp   = (wp_inc >= len) ? '0 : wp_inc[IDX_W-1:0];
        n_fill = (r_fill < len) ? r_fill + CNT_W'(1) : len;
    end

    // rank test: candidate is the median if #less <= fill/2 < #less_or_equal
    assign cand_val = r_store[r_cand];
    assign rank     = r_fill >> 1;

    always_comb begin
        less_cnt = '0;
        le_cnt   = '0;
        for (int j = 0; j < MAX_WINDOW; j++) begin
            if (CNT_W'(j) < r_fill) begin
                if (r_store[j] < cand_val) begin
                    less_cnt = less_cnt + CNT_W'(1);
                end
                if (r_store[j] <= cand_val) begin
                    le_cnt = le_cnt + CNT_W'(1);
                end
            end
        end
        o_stat.hit       = (less_cnt <= rank) && (le_cnt > rank);
        o_stat.cand_last = (CNT_W'(r_cand) + CNT_W'(1)) >= r_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws   <= WS_RESET;
            r_wp   <= '0;
            r_fill <= '0;
        end else if (i_cfg_wr_en) begin
            r_ws   <= i_cfg_wr_data;
            r_wp   <= '0;
            r_fill <= '0;
        end else if (i_cmd.wr_sample) begin
            r_wp   <= n_wp;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_sample) begin
            r_store[r_wp] <= i_sample;
            r_cand        <= '0;
        end else if (i_cmd.cand_inc) begin
            r_cand        <= r_cand + IDX_W'(1);
        end
        if (i_cmd.out_load) begin
            r_median <= cand_val;
        end
    end

    assign o_median = r_median;

endmodule

>>> hdl/rmf_checker.sv
// ----------------------------------------------------------------------------
// rmf_checker
// Port-level checks for the running median filter, bound to the top level.
// ----------------------------------------------------------------------------
module rmf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    // no result right out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("median valid after reset");

    // one sample at a time: busy right after an accepted beat
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("sample accepted while busy");

    // a sample is written to the store and scanned before its result is valid
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_out_valid) |=> !i_out_valid)
        else $error("median too early");

    // result held until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("median dropped while stalled");

endmodule

bind running_median_filter rmf_checker u_rmf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (in_valid),
    .i_in_ready  (in_ready),
    .i_out_valid (out_valid),
    .i_out_ready (out_ready)
);
